FILE: hw/rtl/rit_pkg.sv
// Shared types and constants for the repeating interval timer.
package rit_pkg;

  localparam int DefaultTimeWidth = 32;
  localparam int FieldWidth       = 32;
  localparam int CmdWidth         = 3;
  localparam int StatusWidth      = 2;
  localparam int CfgIndexWidth    = 1;

  typedef enum logic [CmdWidth-1:0] {
    CMD_ADVANCE = 3'd0,
    CMD_START   = 3'd1,
    CMD_RESUME  = 3'd2,
    CMD_STOP    = 3'd3,
    CMD_PAUSE   = 3'd4,
    CMD_FIRE    = 3'd5,
    CMD_SETREF  = 3'd6
  } cmd_t;

  typedef enum logic [StatusWidth-1:0] {
    ST_STOPPED = 2'd0,
    ST_RUNNING = 2'd1,
    ST_PAUSED  = 2'd2
  } run_state_t;

  typedef enum logic [CfgIndexWidth-1:0] {
    CFG_PERIOD = 1'b0,
    CFG_LIMIT  = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic                  fired;
    logic [StatusWidth-1:0] run_status;
    logic [FieldWidth-1:0] fire_count;
    logic [FieldWidth-1:0] elapsed_ms;
    logic [FieldWidth-1:0] remaining_ms;
  } result_t;

endpackage

FILE: hw/rtl/rit_if.sv
// Valid/ready channel interfaces for timer commands and timer results.
interface rit_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [31:0] reference_value;

  modport source (output valid, output command, output reference_value, input ready);
  modport sink   (input valid, input command, input reference_value, output ready);
endinterface

interface rit_res_if;
  logic        valid;
  logic        ready;
  logic        fired;
  logic [1:0]  run_status;
  logic [31:0] fire_count;
  logic [31:0] elapsed_ms;
  logic [31:0] remaining_ms;

  modport source (output valid, output fired, output run_status, output fire_count,
                  output elapsed_ms, output remaining_ms, input ready);
  modport sink   (input valid, input fired, input run_status, input fire_count,
                  input elapsed_ms, input remaining_ms, output ready);
endinterface

FILE: hw/rtl/rit_engine.sv
// Timer state registers and the per-command update and result logic.
module rit_engine #(
  parameter int TIME_WIDTH = rit_pkg::DefaultTimeWidth
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           step,
  input  logic [rit_pkg::CmdWidth-1:0]   command,
  input  logic [rit_pkg::FieldWidth-1:0] reference_value,
  input  logic [rit_pkg::FieldWidth-1:0] period,
  input  logic [rit_pkg::FieldWidth-1:0] repeat_limit,
  output rit_pkg::result_t               result
);
  import rit_pkg::*;

  localparam int CmpWidth = (TIME_WIDTH > FieldWidth) ? TIME_WIDTH : FieldWidth;

  logic [TIME_WIDTH-1:0] clock_ms, clock_ms_next;
  logic [TIME_WIDTH-1:0] reference_time, reference_time_next;
  logic [TIME_WIDTH-1:0] pause_offset, pause_offset_next;
  logic [FieldWidth-1:0] count_reg, count_reg_next;
  logic                  enable_flag, enable_flag_next;
  run_state_t            status_reg, status_reg_next;

  logic [TIME_WIDTH-1:0] clock_inc;
  logic [TIME_WIDTH-1:0] elapsed_adv;
  logic [TIME_WIDTH-1:0] elapsed_cur;
  logic [TIME_WIDTH-1:0] elapsed_out;
  logic [TIME_WIDTH-1:0] remaining_out;
  logic                  tick_fire;
  logic                  fire;
  logic                  last_fire;

  always_comb begin
    clock_inc   = clock_ms + TIME_WIDTH'(1);
    elapsed_adv = clock_inc - reference_time;
    elapsed_cur = clock_ms - reference_time;
    tick_fire   = enable_flag && (CmpWidth'(elapsed_adv) >= CmpWidth'(period));
    last_fire   = (repeat_limit != '0) && ((repeat_limit - count_reg) == FieldWidth'(1));

    clock_ms_next       = clock_ms;
    reference_time_next = reference_time;
    pause_offset_next   = pause_offset;
    count_reg_next      = count_reg;
    enable_flag_next    = enable_flag;
    status_reg_next     = status_reg;
    fire                = 1'b0;

    unique case (cmd_t'(command))
      CMD_ADVANCE: begin
        clock_ms_next = clock_inc;
        fire          = tick_fire;
      end
      CMD_START: begin
        reference_time_next = clock_ms;
        enable_flag_next    = 1'b1;
        count_reg_next      = '0;
        status_reg_next     = ST_RUNNING;
      end
      CMD_RESUME: begin
        reference_time_next = clock_ms - pause_offset;
        if (status_reg == ST_STOPPED) begin
          count_reg_next = '0;
        end
        enable_flag_next = 1'b1;
        status_reg_next  = ST_RUNNING;
      end
      CMD_STOP: begin
        enable_flag_next = 1'b0;
        count_reg_next   = '0;
        status_reg_next  = ST_STOPPED;
      end
      CMD_PAUSE: begin
        pause_offset_next = elapsed_cur;
        enable_flag_next  = 1'b0;
        status_reg_next   = ST_PAUSED;
      end
      CMD_FIRE: begin
        fire = 1'b1;
      end
      CMD_SETREF: begin
        reference_time_next = TIME_WIDTH'(reference_value);
      end
      default: begin
      end
    endcase

    if (fire) begin
      reference_time_next = clock_ms_next;
      count_reg_next      = count_reg + FieldWidth'(1);
      if (last_fire) begin
        enable_flag_next = 1'b0;
      end
    end

    elapsed_out   = clock_ms_next - reference_time_next;
    remaining_out = (period == '0) ? '0 : (TIME_WIDTH'(period) - elapsed_out);

    result.fired        = fire;
    result.run_status   = status_reg_next;
    result.fire_count   = count_reg_next;
    result.elapsed_ms   = FieldWidth'(elapsed_out);
    result.remaining_ms = FieldWidth'(remaining_out);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_ms       <= '0;
      reference_time <= '0;
      pause_offset   <= '0;
      count_reg      <= '0;
      enable_flag    <= 1'b0;
      status_reg     <= ST_STOPPED;
    end else if (step) begin
      clock_ms       <= clock_ms_next;
      reference_time <= reference_time_next;
      pause_offset   <= pause_offset_next;
      count_reg      <= count_reg_next;
      enable_flag    <= enable_flag_next;
      status_reg     <= status_reg_next;
    end
  end

endmodule

FILE: hw/rtl/repeating_interval_timer_core.sv
// Repeating interval timer core: configuration, command channel and result register.
// Latency: a result is valid in the cycle after its command transfer.
// Throughput: one command per cycle; a new command is taken while the held
// result is being taken, so only a stalled result register holds off input.
// Reset: synchronous; clears the clock, reference, offset, count, enable,
// status and both configuration registers, and empties the result register.
module repeating_interval_timer_core #(
  parameter int TIME_WIDTH = rit_pkg::DefaultTimeWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [rit_pkg::CfgIndexWidth-1:0] cfg_index,
  input  logic [rit_pkg::FieldWidth-1:0]    cfg_data,
  rit_cmd_if.sink                           req,
  rit_res_if.source                         rsp
);
  import rit_pkg::*;

  logic [FieldWidth-1:0] period;
  logic [FieldWidth-1:0] repeat_limit;
  logic                  step;
  logic                  rsp_valid;
  result_t               result;
  result_t               result_held;

  always_ff @(posedge clk) begin
    if (rst) begin
      period       <= '0;
      repeat_limit <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_PERIOD: period       <= cfg_data;
        CFG_LIMIT:  repeat_limit <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign req.ready = !rsp_valid || rsp.ready;
  assign step      = req.valid && req.ready;

  rit_engine #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_engine (
    .clk            (clk),
    .rst            (rst),
    .step           (step),
    .command        (req.command),
    .reference_value(req.reference_value),
    .period         (period),
    .repeat_limit   (repeat_limit),
    .result         (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (req.ready) begin
      rsp_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result_held <= result;
    end
  end

  assign rsp.valid        = rsp_valid;
  assign rsp.fired        = result_held.fired;
  assign rsp.run_status   = result_held.run_status;
  assign rsp.fire_count   = result_held.fire_count;
  assign rsp.elapsed_ms   = result_held.elapsed_ms;
  assign rsp.remaining_ms = result_held.remaining_ms;

endmodule
